/* design/phong_vertex_shader_core_assert.svh */
// ----------------------------------------------------------------------------
// Phong vertex shader assertion macros
// Concurrent assertion forms used by the shader core.
// ----------------------------------------------------------------------------
`ifndef PHONG_VERTEX_SHADER_CORE_ASSERT_SVH
`define PHONG_VERTEX_SHADER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PVS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PVS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

/* design/pvs_pkg.sv */
// ----------------------------------------------------------------------------
// Phong vertex shader package
// Widths, latencies, register indexes and shared helper functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pvs_pkg;

  localparam int VEC_W     = 16;
  localparam int DIFF_W    = 17;
  localparam int SUM_W     = 34;
  localparam int ROOT_W    = 31;
  localparam int REM_W     = 2 * ROOT_W;
  localparam int NUM_W     = 45;
  localparam int QUOT_W    = 15;
  localparam int UNIT_W    = 15;
  localparam int RAY_W     = 22;
  localparam int FRAC_BITS = 14;
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 3;

  localparam logic [UNIT_W-1:0] ONE_Q14 = UNIT_W'(1) << FRAC_BITS;

  localparam int LOG_BITS = 16;
  localparam int EXP_BITS = 16;
  localparam int VD_LAT   = ROOT_W + QUOT_W + 3;
  localparam int PW_LAT   = LOG_BITS + EXP_BITS + 4;
  localparam int TOTAL_LAT = 3 + VD_LAT + 3 + PW_LAT + 4;

  localparam logic [CFG_IDX_W-1:0] CFG_VIEWER    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIFFUSE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPECULAR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_AMBIENT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SHININESS = 3'd5;

  typedef logic [UNIT_W-1:0] unit_t;

  function automatic unit_t pvs_clamp_unit(input logic signed [31:0] x);
    if (x < 0) begin
      return '0;
    end else if (x > 32'sd16384) begin
      return ONE_Q14;
    end else begin
      return x[UNIT_W-1:0];
    end
  endfunction

  // Factor j of the exponent table is 2^(-2^-j) at Q1.30, built by
  // repeated square roots starting from one half.
  function automatic logic [30:0] pvs_fac(input int j);
    logic [63:0] fac;
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bit_m;
    fac = 64'd1 << 29;
    for (int i = 1; i <= j; i++) begin
      v = fac << 30;
      res = '0;
      bit_m = 64'd1 << 62;
      for (int b = 0; b < 32; b++) begin
        if (v >= res + bit_m) begin
          v = v - (res + bit_m);
          res = (res >> 1) + bit_m;
        end else begin
          res = res >> 1;
        end
        bit_m = bit_m >> 2;
      end
      fac = res;
    end
    return fac[30:0];
  endfunction

endpackage

/* design/pvs_view_dir.sv */
// ----------------------------------------------------------------------------
// Phong vertex shader view direction
// Pipelined square root of the squared distance, then three pipelined
// restoring dividers that normalize the viewer offset to Q2.14.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pvs_view_dir (
  input  logic                              clk,
  input  logic                              en,
  input  logic [pvs_pkg::SUM_W-1:0]         sum,
  input  logic signed [pvs_pkg::DIFF_W-1:0] d [3],
  output logic signed [pvs_pkg::VEC_W-1:0]  v [3]
);
  import pvs_pkg::*;

  logic [REM_W-1:0]         sq_rem_r  [ROOT_W+1];
  logic [ROOT_W-1:0]        sq_root_r [ROOT_W+1];
  logic signed [DIFF_W-1:0] sq_d_r    [ROOT_W+1][3];
  logic                     sq_z_r    [ROOT_W+1];

  logic [NUM_W-1:0]  dv_num_r [QUOT_W+1][3];
  logic [QUOT_W-1:0] dv_q_r   [QUOT_W+1][3];
  logic              dv_neg_r [QUOT_W+1][3];
  logic [ROOT_W-1:0] dv_s_r   [QUOT_W+1];
  logic              dv_z_r   [QUOT_W+1];

  logic signed [VEC_W-1:0] v_r [3];
  logic [VEC_W-1:0]        mag [3];

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rem_r[0]  <= {sum, {(REM_W-SUM_W){1'b0}}};
      sq_root_r[0] <= '0;
      sq_z_r[0]    <= (sum == '0);
      for (int k = 0; k < 3; k++) begin
        sq_d_r[0][k] <= d[k];
      end
    end
  end

  for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
    localparam int B = ROOT_W - 1 - i;
    logic [REM_W-1:0] trial;
    assign trial = (REM_W'(sq_root_r[i]) << (B + 1)) + (REM_W'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if (en) begin
        if (sq_rem_r[i] >= trial) begin
          sq_rem_r[i+1]  <= sq_rem_r[i] - trial;
          sq_root_r[i+1] <= sq_root_r[i] | (ROOT_W'(1) << B);
        end else begin
          sq_rem_r[i+1]  <= sq_rem_r[i];
          sq_root_r[i+1] <= sq_root_r[i];
        end
        sq_z_r[i+1] <= sq_z_r[i];
        for (int k = 0; k < 3; k++) begin
          sq_d_r[i+1][k] <= sq_d_r[i][k];
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag[k] = sq_d_r[ROOT_W][k][DIFF_W-1] ? VEC_W'(-sq_d_r[ROOT_W][k])
                                            : VEC_W'(sq_d_r[ROOT_W][k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_s_r[0] <= sq_root_r[ROOT_W];
      dv_z_r[0] <= sq_z_r[ROOT_W];
      for (int k = 0; k < 3; k++) begin
        dv_num_r[0][k] <= (NUM_W'(mag[k]) << 28) + NUM_W'(sq_root_r[ROOT_W] >> 1);
        dv_q_r[0][k]   <= '0;
        dv_neg_r[0][k] <= sq_d_r[ROOT_W][k][DIFF_W-1];
      end
    end
  end

  for (genvar i = 0; i < QUOT_W; i++) begin : g_div
    localparam int B = QUOT_W - 1 - i;
    logic [NUM_W-1:0] dvs;
    assign dvs = NUM_W'(dv_s_r[i]) << B;
    always_ff @(posedge clk) begin
      if (en) begin
        dv_s_r[i+1] <= dv_s_r[i];
        dv_z_r[i+1] <= dv_z_r[i];
        for (int k = 0; k < 3; k++) begin
          dv_neg_r[i+1][k] <= dv_neg_r[i][k];
          if (dv_num_r[i][k] >= dvs) begin
            dv_num_r[i+1][k] <= dv_num_r[i][k] - dvs;
            dv_q_r[i+1][k]   <= dv_q_r[i][k] | (QUOT_W'(1) << B);
          end else begin
            dv_num_r[i+1][k] <= dv_num_r[i][k];
            dv_q_r[i+1][k]   <= dv_q_r[i][k];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        if (dv_z_r[QUOT_W]) begin
          v_r[k] <= '0;
        end else if (dv_neg_r[QUOT_W][k]) begin
          v_r[k] <= -VEC_W'(dv_q_r[QUOT_W][k]);
        end else begin
          v_r[k] <= VEC_W'(dv_q_r[QUOT_W][k]);
        end
      end
    end
  end

  assign v = v_r;

endmodule

/* design/pvs_spec_pow.sv */
// ----------------------------------------------------------------------------
// Phong vertex shader specular power
// Raises a Q1.14 base to a Q8.8 exponent through a pipelined base-two
// logarithm, one multiply, and a pipelined product of exponent factors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pvs_spec_pow (
  input  logic                  clk,
  input  logic                  en,
  input  logic [pvs_pkg::UNIT_W-1:0] base,
  input  logic [15:0]           sh,
  output logic [pvs_pkg::UNIT_W-1:0] spec
);
  import pvs_pkg::*;

  localparam int M_W   = 15;
  localparam int T_W   = 20;
  localparam int P_W   = 28;
  localparam int ACC_W = 31;

  logic [3:0]     h;
  logic [3:0]     e0;
  logic [M_W-1:0] m0;

  logic [M_W-1:0]      lg_m_r  [LOG_BITS+1];
  logic [LOG_BITS-1:0] lg_f_r  [LOG_BITS+1];
  logic [3:0]          lg_e_r  [LOG_BITS+1];
  logic [15:0]         lg_sh_r [LOG_BITS+1];
  logic                lg_fz_r [LOG_BITS+1];
  logic                lg_fo_r [LOG_BITS+1];

  logic [T_W-1:0] t_r;
  logic [15:0]    t_sh_r;
  logic           t_fz_r;
  logic           t_fo_r;

  logic [T_W+15:0] tp;

  logic [ACC_W-1:0] ex_acc_r [EXP_BITS+1];
  logic [15:0]      ex_fp_r  [EXP_BITS+1];
  logic [3:0]       ex_ip_r  [EXP_BITS+1];
  logic             ex_fz_r  [EXP_BITS+1];
  logic             ex_fo_r  [EXP_BITS+1];

  logic [4:0]  sft;
  logic [31:0] rnd;
  logic [31:0] res;
  logic [UNIT_W-1:0] spec_r;

  always_comb begin
    h = '0;
    for (int j = 0; j < FRAC_BITS; j++) begin
      if (base[j]) begin
        h = 4'(j);
      end
    end
    e0 = 4'(FRAC_BITS) - h;
    m0 = M_W'(base[FRAC_BITS-1:0]) << e0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lg_m_r[0]  <= m0;
      lg_f_r[0]  <= '0;
      lg_e_r[0]  <= e0;
      lg_sh_r[0] <= sh;
      lg_fz_r[0] <= (base == '0);
      lg_fo_r[0] <= base[FRAC_BITS] || (sh == '0);
    end
  end

  for (genvar i = 0; i < LOG_BITS; i++) begin : g_log
    logic [2*M_W-1:0] sq;
    logic [M_W:0]     m2;
    assign sq = (2*M_W)'(lg_m_r[i]) * (2*M_W)'(lg_m_r[i]);
    assign m2 = sq[2*M_W-1:FRAC_BITS];
    always_ff @(posedge clk) begin
      if (en) begin
        lg_m_r[i+1]  <= m2[M_W] ? m2[M_W:1] : m2[M_W-1:0];
        lg_f_r[i+1]  <= {lg_f_r[i][LOG_BITS-2:0], m2[M_W]};
        lg_e_r[i+1]  <= lg_e_r[i];
        lg_sh_r[i+1] <= lg_sh_r[i];
        lg_fz_r[i+1] <= lg_fz_r[i];
        lg_fo_r[i+1] <= lg_fo_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r    <= (T_W'(lg_e_r[LOG_BITS]) << 16) - T_W'(lg_f_r[LOG_BITS]);
      t_sh_r <= lg_sh_r[LOG_BITS];
      t_fz_r <= lg_fz_r[LOG_BITS];
      t_fo_r <= lg_fo_r[LOG_BITS];
    end
  end

  assign tp = (T_W+16)'(t_r) * (T_W+16)'(t_sh_r);

  always_ff @(posedge clk) begin
    if (en) begin
      ex_acc_r[0] <= ACC_W'(1) << 30;
      ex_fp_r[0]  <= tp[23:8];
      ex_ip_r[0]  <= tp[27:24];
      ex_fo_r[0]  <= t_fo_r;
      ex_fz_r[0]  <= t_fz_r || (!t_fo_r && (tp[P_W+7:24] > 12'd14));
    end
  end

  for (genvar i = 0; i < EXP_BITS; i++) begin : g_exp
    localparam logic [ACC_W-1:0] FAC = pvs_fac(i + 1);
    logic [2*ACC_W-1:0] prod;
    assign prod = (2*ACC_W)'(ex_acc_r[i]) * (2*ACC_W)'(FAC);
    always_ff @(posedge clk) begin
      if (en) begin
        ex_acc_r[i+1] <= ex_fp_r[i][EXP_BITS-1-i] ? prod[ACC_W+29:30] : ex_acc_r[i];
        ex_fp_r[i+1]  <= ex_fp_r[i];
        ex_ip_r[i+1]  <= ex_ip_r[i];
        ex_fz_r[i+1]  <= ex_fz_r[i];
        ex_fo_r[i+1]  <= ex_fo_r[i];
      end
    end
  end

  always_comb begin
    sft = 5'd16 + 5'(ex_ip_r[EXP_BITS]);
    rnd = 32'(ex_acc_r[EXP_BITS]) + (32'd1 << (sft - 5'd1));
    res = rnd >> sft;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (ex_fz_r[EXP_BITS]) begin
        spec_r <= '0;
      end else if (ex_fo_r[EXP_BITS]) begin
        spec_r <= ONE_Q14;
      end else if (res > 32'(ONE_Q14)) begin
        spec_r <= ONE_Q14;
      end else begin
        spec_r <= res[UNIT_W-1:0];
      end
    end
  end

  assign spec = spec_r;

endmodule

/* design/phong_vertex_shader_core.sv */
// ----------------------------------------------------------------------------
// Phong vertex shader core
// Per-vertex Phong lighting in fixed point with one colour per request.
// ----------------------------------------------------------------------------
// The core takes one vertex request per clock while not stalled and returns
// one shaded colour per request, in order. The depth is set by the bit-serial
// square root and dividers of the view direction and by the logarithm and
// exponent chain of the specular power, each unrolled into one register stage
// per result bit. A held result on the output freezes the whole pipeline, so
// in_stall rises only while out_valid waits on out_stall.
// Configuration registers are read directly by the pipeline and must only be
// written while no request is in flight.
`timescale 1ns / 1ps

`include "phong_vertex_shader_core_assert.svh"

module phong_vertex_shader_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [15:0]                 in_vertex_x,
  input  logic signed [15:0]                 in_vertex_y,
  input  logic signed [15:0]                 in_vertex_z,
  input  logic signed [15:0]                 in_normal_x,
  input  logic signed [15:0]                 in_normal_y,
  input  logic signed [15:0]                 in_normal_z,
  input  logic signed [15:0]                 in_light_dir_x,
  input  logic signed [15:0]                 in_light_dir_y,
  input  logic signed [15:0]                 in_light_dir_z,
  input  logic [15:0]                        in_attenuation,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [14:0]                        out_red,
  output logic [14:0]                        out_green,
  output logic [14:0]                        out_blue,
  input  logic                               cfg_wr_en,
  input  logic [pvs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pvs_pkg::CFG_W-1:0]          cfg_data
);
  import pvs_pkg::*;

  localparam int SB_LAT = VD_LAT - 2;
  localparam int Q3_IDX = 3 + VD_LAT + 2;

  logic [CFG_W-1:0] cfg_viewer_r;
  logic [CFG_W-1:0] cfg_light_r;
  logic [CFG_W-1:0] cfg_diffuse_r;
  logic [CFG_W-1:0] cfg_specular_r;
  logic [CFG_W-1:0] cfg_ambient_r;
  logic [15:0]      cfg_shin_r;

  logic en;
  logic vld_r [TOTAL_LAT];

  logic signed [VEC_W-1:0] vtx [3];
  logic signed [VEC_W-1:0] nrm [3];
  logic signed [VEC_W-1:0] ldir [3];

  logic signed [DIFF_W-1:0] s1_d_r [3];
  logic signed [31:0]       s1_pnl_r [3];
  logic signed [VEC_W-1:0]  s1_n_r [3];
  logic signed [VEC_W-1:0]  s1_l_r [3];
  logic [15:0]              s1_att_r;

  logic signed [33:0]       d_ext [3];
  logic signed [33:0]       s2_nl28_r;
  logic [32:0]              s2_dd_r [3];
  logic signed [DIFF_W-1:0] s2_d_r [3];
  logic signed [VEC_W-1:0]  s2_n_r [3];
  logic signed [VEC_W-1:0]  s2_l_r [3];
  logic [15:0]              s2_att_r;

  logic signed [18:0]       s3_nl_r;
  logic [SUM_W-1:0]         s3_sum_r;
  logic signed [DIFF_W-1:0] s3_d_r [3];
  logic signed [VEC_W-1:0]  s3_n_r [3];
  logic signed [VEC_W-1:0]  s3_l_r [3];
  logic [15:0]              s3_att_r;

  logic signed [34:0]      s4_nlp_r [3];
  logic signed [VEC_W-1:0] s4_l_r [3];
  unit_t                   s4_diff_r;
  logic [15:0]             s4_att_r;

  logic signed [RAY_W-1:0] s5_r_r [3];
  unit_t                   s5_diff_r;
  logic [15:0]             s5_att_r;

  logic signed [RAY_W-1:0] sb_r_r [SB_LAT][3];
  unit_t                   sb_diff_r [SB_LAT];
  logic [15:0]             sb_att_r [SB_LAT];

  logic signed [VEC_W-1:0] vdir [3];

  logic signed [37:0] q1_pvr_r [3];
  unit_t              q1_diff_r;
  logic [15:0]        q1_att_r;
  logic signed [39:0] q2_vr28_r;
  unit_t              q2_diff_r;
  logic [15:0]        q2_att_r;
  unit_t              q3_base_r;
  unit_t              q3_diff_r;
  logic [15:0]        q3_att_r;

  unit_t       pd_diff_r [PW_LAT];
  logic [15:0] pd_att_r [PW_LAT];
  unit_t       spec;

  logic [30:0] c1_dterm_r [3];
  logic [30:0] c1_sterm_r [3];
  logic [15:0] c1_att_r;
  logic [17:0] c2_inner_r [3];
  logic [31:0] c2_al_r [3];
  logic [49:0] c3_prod [3];
  logic [21:0] c3_lit_r [3];
  logic [22:0] tot [3];
  unit_t       out_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_viewer_r   <= '0;
      cfg_light_r    <= '0;
      cfg_diffuse_r  <= '0;
      cfg_specular_r <= '0;
      cfg_ambient_r  <= '0;
      cfg_shin_r     <= 16'd256;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_VIEWER:    cfg_viewer_r   <= cfg_data;
        CFG_LIGHT:     cfg_light_r    <= cfg_data;
        CFG_DIFFUSE:   cfg_diffuse_r  <= cfg_data;
        CFG_SPECULAR:  cfg_specular_r <= cfg_data;
        CFG_AMBIENT:   cfg_ambient_r  <= cfg_data;
        CFG_SHININESS: cfg_shin_r     <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  assign en        = !vld_r[TOTAL_LAT-1] || !out_stall;
  assign in_stall  = !en;
  assign out_valid = vld_r[TOTAL_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TOTAL_LAT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < TOTAL_LAT; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  assign vtx[0]  = in_vertex_x;
  assign vtx[1]  = in_vertex_y;
  assign vtx[2]  = in_vertex_z;
  assign nrm[0]  = in_normal_x;
  assign nrm[1]  = in_normal_y;
  assign nrm[2]  = in_normal_z;
  assign ldir[0] = in_light_dir_x;
  assign ldir[1] = in_light_dir_y;
  assign ldir[2] = in_light_dir_z;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s1_d_r[k]   <= {cfg_viewer_r[16*k+15], cfg_viewer_r[16*k +: 16]} -
                       {vtx[k][VEC_W-1], vtx[k]};
        s1_pnl_r[k] <= 32'(nrm[k]) * 32'(ldir[k]);
        s1_n_r[k]   <= nrm[k];
        s1_l_r[k]   <= ldir[k];
      end
      s1_att_r <= in_attenuation;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d_ext[k] = 34'(s1_d_r[k]) * 34'(s1_d_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_nl28_r <= 34'(s1_pnl_r[0]) + 34'(s1_pnl_r[1]) + 34'(s1_pnl_r[2]);
      for (int k = 0; k < 3; k++) begin
        s2_dd_r[k] <= d_ext[k][32:0];
        s2_d_r[k]  <= s1_d_r[k];
        s2_n_r[k]  <= s1_n_r[k];
        s2_l_r[k]  <= s1_l_r[k];
      end
      s2_att_r <= s1_att_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_nl_r  <= 19'(s2_nl28_r >>> FRAC_BITS);
      s3_sum_r <= SUM_W'(s2_dd_r[0]) + SUM_W'(s2_dd_r[1]) + SUM_W'(s2_dd_r[2]);
      for (int k = 0; k < 3; k++) begin
        s3_d_r[k] <= s2_d_r[k];
        s3_n_r[k] <= s2_n_r[k];
        s3_l_r[k] <= s2_l_r[k];
      end
      s3_att_r <= s2_att_r;
    end
  end

  pvs_view_dir u_view_dir (
    .clk (clk),
    .en  (en),
    .sum (s3_sum_r),
    .d   (s3_d_r),
    .v   (vdir)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s4_nlp_r[k] <= 35'(s3_nl_r) * 35'(s3_n_r[k]);
        s4_l_r[k]   <= s3_l_r[k];
      end
      s4_diff_r <= pvs_clamp_unit(32'(s3_nl_r));
      s4_att_r  <= s3_att_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s5_r_r[k] <= RAY_W'(s4_nlp_r[k] >>> (FRAC_BITS - 1)) - RAY_W'(s4_l_r[k]);
      end
      s5_diff_r <= s4_diff_r;
      s5_att_r  <= s4_att_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        sb_r_r[0][k] <= s5_r_r[k];
      end
      sb_diff_r[0] <= s5_diff_r;
      sb_att_r[0]  <= s5_att_r;
      for (int i = 1; i < SB_LAT; i++) begin
        for (int k = 0; k < 3; k++) begin
          sb_r_r[i][k] <= sb_r_r[i-1][k];
        end
        sb_diff_r[i] <= sb_diff_r[i-1];
        sb_att_r[i]  <= sb_att_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        q1_pvr_r[k] <= 38'(vdir[k]) * 38'(sb_r_r[SB_LAT-1][k]);
      end
      q1_diff_r <= sb_diff_r[SB_LAT-1];
      q1_att_r  <= sb_att_r[SB_LAT-1];
      q2_vr28_r <= 40'(q1_pvr_r[0]) + 40'(q1_pvr_r[1]) + 40'(q1_pvr_r[2]);
      q2_diff_r <= q1_diff_r;
      q2_att_r  <= q1_att_r;
      q3_base_r <= pvs_clamp_unit(32'(q2_vr28_r >>> FRAC_BITS));
      q3_diff_r <= q2_diff_r;
      q3_att_r  <= q2_att_r;
    end
  end

  pvs_spec_pow u_spec_pow (
    .clk  (clk),
    .en   (en),
    .base (q3_base_r),
    .sh   (cfg_shin_r),
    .spec (spec)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      pd_diff_r[0] <= q3_diff_r;
      pd_att_r[0]  <= q3_att_r;
      for (int i = 1; i < PW_LAT; i++) begin
        pd_diff_r[i] <= pd_diff_r[i-1];
        pd_att_r[i]  <= pd_att_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        c1_dterm_r[k] <= 31'(cfg_diffuse_r[16*k +: 16]) * 31'(pd_diff_r[PW_LAT-1]);
        c1_sterm_r[k] <= 31'(cfg_specular_r[16*k +: 16]) * 31'(spec);
        c2_inner_r[k] <= 18'((32'(c1_dterm_r[k]) + 32'(c1_sterm_r[k])) >> FRAC_BITS);
        c2_al_r[k]    <= 32'(c1_att_r) * 32'(cfg_light_r[16*k +: 16]);
        c3_lit_r[k]   <= c3_prod[k][49:28];
        out_r[k]      <= (tot[k] > 23'(ONE_Q14)) ? ONE_Q14 : tot[k][UNIT_W-1:0];
      end
      c1_att_r <= pd_att_r[PW_LAT-1];
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      c3_prod[k] = 50'(c2_al_r[k]) * 50'(c2_inner_r[k]);
      tot[k]     = 23'(cfg_ambient_r[16*k +: 16]) + 23'(c3_lit_r[k]);
    end
  end

  assign out_red   = out_r[0];
  assign out_green = out_r[1];
  assign out_blue  = out_r[2];

  `PVS_ASSERT_NXT(a_accept_enters, in_valid && !in_stall, vld_r[0])
  `PVS_ASSERT_IMP(a_base_unit, vld_r[Q3_IDX], q3_base_r <= ONE_Q14)
  `PVS_ASSERT_IMP(a_out_clamped, out_valid, (out_red <= ONE_Q14) && (out_green <= ONE_Q14) && (out_blue <= ONE_Q14))

endmodule
